>>> rtl/bfr_pkg.sv
// Package for the byte frame receiver: state type, frame codes and control/status structs.
package bfr_pkg;

    localparam logic [7:0] TERM_BYTE = 8'h17;
    localparam logic [7:0] ACK_BYTE  = 8'h06;
    localparam logic [7:0] NAK_BYTE  = 8'h15;

    localparam logic [7:0] TYPE_TEXT  = 8'd1;
    localparam logic [7:0] TYPE_IMAGE = 8'd2;

    localparam logic [7:0] MODE_RGB888 = 8'd1;
    localparam logic [7:0] MODE_PAIR   = 8'd2;

    localparam logic [4:0] INFO_LEN_TEXT  = 5'd6;
    localparam logic [4:0] INFO_LEN_IMAGE = 5'd8;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_NAK   = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;
    localparam logic [1:0] KIND_PIXEL = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHECKSUM = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // Bytes taken from the payload memory for one emitted item.
    localparam logic [1:0] BPI_NONE = 2'd0;
    localparam logic [1:0] BPI_TEXT = 2'd1;
    localparam logic [1:0] BPI_PAIR = 2'd2;
    localparam logic [1:0] BPI_RGB  = 2'd3;

    typedef enum logic [3:0] {
        S_TYPE,
        S_SIZE,
        S_INFO,
        S_PAYLOAD,
        S_TERM,
        S_CHECK,
        S_HANG,
        S_RD,
        S_CAP
    } t_state;

    typedef struct packed {
        logic ld_type;
        logic ld_size;
        logic ld_info;
        logic ld_payload;
        logic ld_resp;
        logic rd_issue;
        logic cap_byte;
        logic ld_item;
    } t_cmd;

    typedef struct packed {
        logic type_ok;
        logic info_done;
        logic left_nz;
        logic left_is_one;
        logic is_term;
        logic resp_last;
        logic group_end;
        logic item_last;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/bfr_ctrl.sv
// Controller state machine of the byte frame receiver.
module bfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    input  bfr_pkg::t_sts i_sts,
    output logic          o_rx_stall,
    output bfr_pkg::t_cmd o_cmd
);

    bfr_pkg::t_state r_state;
    bfr_pkg::t_state n_state;
    logic            acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfr_pkg::S_TYPE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_stall = 1'b0;
        acc        = 1'b0;
        case (r_state)
            bfr_pkg::S_TYPE: begin
                acc = i_rx_valid;
                if (acc) begin
                    o_cmd.ld_type = 1'b1;
                    n_state = bfr_pkg::S_SIZE;
                end
            end
            bfr_pkg::S_SIZE: begin
                acc = i_rx_valid;
                if (acc) begin
                    o_cmd.ld_size = 1'b1;
                    n_state = i_sts.type_ok ? bfr_pkg::S_INFO : bfr_pkg::S_HANG;
                end
            end
            bfr_pkg::S_INFO: begin
                acc = i_rx_valid;
                if (acc) begin
                    o_cmd.ld_info = 1'b1;
                    if (i_sts.info_done) begin
                        n_state = i_sts.left_nz ? bfr_pkg::S_PAYLOAD : bfr_pkg::S_TERM;
                    end
                end
            end
            bfr_pkg::S_PAYLOAD: begin
                acc = i_rx_valid;
                if (acc) begin
                    o_cmd.ld_payload = 1'b1;
                    if (i_sts.left_is_one) begin
                        n_state = bfr_pkg::S_TERM;
                    end
                end
            end
            bfr_pkg::S_TERM: begin
                acc = i_rx_valid;
                if (acc && i_sts.is_term) begin
                    n_state = bfr_pkg::S_CHECK;
                end
            end
            bfr_pkg::S_CHECK: begin
                o_rx_stall = !i_sts.out_free;
                acc = i_rx_valid && i_sts.out_free;
                if (acc) begin
                    o_cmd.ld_resp = 1'b1;
                    n_state = i_sts.resp_last ? bfr_pkg::S_TYPE : bfr_pkg::S_RD;
                end
            end
            bfr_pkg::S_HANG: begin
                acc = i_rx_valid;
            end
            bfr_pkg::S_RD: begin
                o_rx_stall = 1'b1;
                o_cmd.rd_issue = 1'b1;
                n_state = bfr_pkg::S_CAP;
            end
            bfr_pkg::S_CAP: begin
                o_rx_stall = 1'b1;
                if (!i_sts.group_end) begin
                    o_cmd.cap_byte = 1'b1;
                    n_state = bfr_pkg::S_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = i_sts.item_last ? bfr_pkg::S_TYPE : bfr_pkg::S_RD;
                end
            end
            default: begin
                n_state = bfr_pkg::S_HANG;
            end
        endcase
    end

endmodule

>>> rtl/bfr_dp.sv
// Datapath of the byte frame receiver: header registers, payload memory and output register.
module bfr_dp #(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bfr_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_item_stall,
    output bfr_pkg::t_sts o_sts,
    output logic          o_item_valid,
    output logic [1:0]    o_item_kind,
    output logic [15:0]   o_item_value,
    output logic [15:0]   o_pos_x,
    output logic [15:0]   o_pos_y,
    output logic [1:0]    o_error_code,
    output logic          o_last_item
);

    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int IDX_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [7:0] CAP = 8'(PAYLOAD_BYTES);

    logic [3:0]        r_header_index;
    logic [7:0]        r_frame_type;
    logic [7:0]        r_size;
    logic [7:0]        r_left;
    logic [7:0]        r_xor;
    logic [7:0]        r_info [0:7];
    logic [7:0]        r_mem [0:PAYLOAD_BYTES-1];
    logic [7:0]        r_rd_data;
    logic [IDX_W-1:0]  r_rd_addr;
    logic [1:0]        r_sub;
    logic [7:0]        r_b0;
    logic [7:0]        r_b1;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [15:0]       r_value;
    logic [15:0]       r_pos_x;
    logic [15:0]       r_pos_y;
    logic [1:0]        r_err;
    logic              r_last;

    logic [4:0]        info_len;
    logic [4:0]        hdr_next;
    logic [7:0]        wr_idx;
    logic [1:0]        bpi;
    logic              overflow;
    logic              bad_sum;
    logic [8:0]        next_end;
    logic [15:0]       item_val;

    assign info_len = (r_frame_type == bfr_pkg::TYPE_TEXT) ?
                      bfr_pkg::INFO_LEN_TEXT : bfr_pkg::INFO_LEN_IMAGE;
    assign hdr_next = {1'b0, r_header_index} + 5'd1;
    assign wr_idx   = r_size - r_left;
    assign overflow = r_size > CAP;
    assign bad_sum  = i_rx_byte != r_xor;

    always_comb begin
        if (r_frame_type == bfr_pkg::TYPE_TEXT) begin
            bpi = bfr_pkg::BPI_TEXT;
        end else if (r_info[6] == bfr_pkg::MODE_RGB888) begin
            bpi = bfr_pkg::BPI_RGB;
        end else if (r_info[6] == bfr_pkg::MODE_PAIR) begin
            bpi = bfr_pkg::BPI_PAIR;
        end else begin
            bpi = bfr_pkg::BPI_NONE;
        end
    end

    // End of the group after the current one, against the payload size.
    assign next_end = {{(9 - IDX_W){1'b0}}, r_rd_addr} + {7'd0, bpi};

    always_comb begin
        case (bpi)
            bfr_pkg::BPI_RGB:  item_val = {r_b0[7:3], r_b1[7:2], r_rd_data[7:3]};
            bfr_pkg::BPI_PAIR: item_val = {r_b0, r_rd_data};
            default:           item_val = {8'd0, r_rd_data};
        endcase
    end

    always_comb begin
        o_sts.type_ok     = (r_frame_type == bfr_pkg::TYPE_TEXT) ||
                            (r_frame_type == bfr_pkg::TYPE_IMAGE);
        o_sts.info_done   = hdr_next >= info_len;
        o_sts.left_nz     = r_left != 8'd0;
        o_sts.left_is_one = r_left == 8'd1;
        o_sts.is_term     = i_rx_byte == bfr_pkg::TERM_BYTE;
        o_sts.resp_last   = overflow || bad_sum || (bpi == bfr_pkg::BPI_NONE) ||
                            ({6'd0, bpi} > r_size);
        o_sts.group_end   = (r_sub + 2'd1) == bpi;
        o_sts.item_last   = next_end > {1'b0, r_size};
        o_sts.out_free    = !r_out_valid || !i_item_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_index <= '0;
            r_frame_type   <= '0;
            r_size         <= '0;
            r_left         <= '0;
            r_xor          <= '0;
            r_rd_addr      <= '0;
            r_sub          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.ld_type) begin
                r_frame_type   <= i_rx_byte;
                r_header_index <= '0;
                r_xor          <= '0;
            end
            if (i_cmd.ld_size) begin
                r_size         <= i_rx_byte;
                r_left         <= i_rx_byte;
                r_header_index <= '0;
            end
            if (i_cmd.ld_info) begin
                r_header_index <= hdr_next[3:0];
            end
            if (i_cmd.ld_payload) begin
                r_xor  <= r_xor ^ i_rx_byte;
                r_left <= r_left - 8'd1;
            end
            if (i_cmd.ld_resp) begin
                r_rd_addr <= '0;
                r_sub     <= '0;
                r_xor     <= '0;
                r_left    <= '0;
                r_header_index <= '0;
            end
            if (i_cmd.rd_issue) begin
                r_rd_addr <= r_rd_addr + IDX_W'(1);
            end
            if (i_cmd.cap_byte) begin
                r_sub <= r_sub + 2'd1;
            end
            if (i_cmd.ld_item) begin
                r_sub <= '0;
            end
            if (i_cmd.ld_resp || i_cmd.ld_item) begin
                r_out_valid <= 1'b1;
            end else if (!i_item_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_info) begin
            r_info[r_header_index[2:0]] <= i_rx_byte;
        end
        if (i_cmd.cap_byte) begin
            if (r_sub == 2'd0) begin
                r_b0 <= r_rd_data;
            end else begin
                r_b1 <= r_rd_data;
            end
        end
        if (i_cmd.ld_resp) begin
            r_pos_x <= {r_info[0], r_info[1]};
            r_pos_y <= {r_info[2], r_info[3]};
            r_last  <= o_sts.resp_last;
            if (overflow) begin
                r_kind  <= bfr_pkg::KIND_NAK;
                r_value <= {8'd0, bfr_pkg::NAK_BYTE};
                r_err   <= bfr_pkg::ERR_OVERFLOW;
            end else if (bad_sum) begin
                r_kind  <= bfr_pkg::KIND_NAK;
                r_value <= {8'd0, bfr_pkg::NAK_BYTE};
                r_err   <= bfr_pkg::ERR_CHECKSUM;
            end else begin
                r_kind  <= bfr_pkg::KIND_ACK;
                r_value <= {8'd0, bfr_pkg::ACK_BYTE};
                r_err   <= bfr_pkg::ERR_NONE;
            end
        end
        if (i_cmd.ld_item) begin
            r_kind  <= (bpi == bfr_pkg::BPI_TEXT) ? bfr_pkg::KIND_TEXT : bfr_pkg::KIND_PIXEL;
            r_value <= item_val;
            r_err   <= bfr_pkg::ERR_NONE;
            r_last  <= o_sts.item_last;
        end
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_payload && (wr_idx < CAP)) begin
            r_mem[wr_idx[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_addr[ADDR_W-1:0]];
        end
    end

    assign o_item_valid = r_out_valid;
    assign o_item_kind  = r_kind;
    assign o_item_value = r_value;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_error_code = r_err;
    assign o_last_item  = r_last;

endmodule

>>> rtl/byte_frame_receiver_rgb565.sv
// Top level of the byte frame receiver, which deframes serial bytes into responses, text and pixels.
//
// The block takes one received byte per transfer and deframes it: a type byte (1 text, 2 image),
// a size byte, six or eight info bytes, the payload, the terminator 0x17 and an XOR checksum of
// the payload. While a frame is being received, every byte is taken without a stall, even
// while an earlier result still waits in the output register. The checksum byte is taken once
// the output register is free and gives an ACK or a NAK at once. After an ACK the block
// replays the payload from its payload memory, which has a single read port with registered
// data, so every byte read passes through a read state and then a capture state. A text item
// takes one byte, a two-byte pixel two and an RGB888-to-RGB565 pixel three, and an output
// stall holds the replay. The input is stalled during that replay. A frame whose size exceeds
// PAYLOAD_BYTES is consumed in full but answered with a NAK carrying the overflow code. A frame
// type other than text or image leaves the block ignoring every later byte until reset. Each
// result carries the position words from the first four info bytes, and last_item marks the
// final result of a checksum byte.
module byte_frame_receiver_rgb565 #(
    parameter int PAYLOAD_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_item_valid,
    input  logic        i_item_stall,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_item_value,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [1:0]  o_error_code,
    output logic        o_last_item
);

    // Commands from the controller and status from the datapath.
    bfr_pkg::t_cmd cmd;
    bfr_pkg::t_sts sts;

    // The controller decides, from the current phase and the status, which datapath
    // registers take the incoming byte and when a result is loaded into the output register.
    bfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_sts      (sts),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the header registers, the running checksum, the payload memory and
    // the output register that parts the result side from the receive side.
    bfr_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rx_byte    (i_rx_byte),
        .i_item_stall (i_item_stall),
        .o_sts        (sts),
        .o_item_valid (o_item_valid),
        .o_item_kind  (o_item_kind),
        .o_item_value (o_item_value),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_error_code (o_error_code),
        .o_last_item  (o_last_item)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the byte frame receiver: random frames, RGB565 pixels and responses.
module tb_top;
    import bfr_pkg::*;

    localparam int PAYLOAD_BYTES = 32;
    // Frame bytes to send in the random part, not counting stray bytes that the block ignores.
    localparam int RANDOM_BYTES  = 420;
    // A full replay is 33 results, and this drain time covers any late result.
    localparam int DRAIN_CYCLES  = 250;

    // One result item as it appears on the output ports.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [1:0]  err;
        logic        last_item;
    } rx_item_t;

    // One row of directed stimulus. A row with a known result carries it in item and
    // stands in for the predicted results of that byte.
    typedef struct {
        logic [7:0] rx_byte;
        bit         known;
        rx_item_t   item;
    } stim_row_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_rx_valid   = 1'b0;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic        i_item_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_item_valid;
    logic [1:0]  o_item_kind;
    logic [15:0] o_item_value;
    logic [15:0] o_pos_x;
    logic [15:0] o_pos_y;
    logic [1:0]  o_error_code;
    logic        o_last_item;

    byte_frame_receiver_rgb565 #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_stall   (o_rx_stall),
        .i_rx_byte    (i_rx_byte),
        .o_item_valid (o_item_valid),
        .i_item_stall (i_item_stall),
        .o_item_kind  (o_item_kind),
        .o_item_value (o_item_value),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_error_code (o_error_code),
        .o_last_item  (o_last_item)
    );

    always #5 i_clk = ~i_clk;

    // Deframer state mirrored by the testbench. It is advanced once per accepted transfer on
    // the input side, so it always describes what the block has seen so far.
    t_state     rx_phase;
    logic [3:0] info_cnt;
    logic [7:0] frame_kind;
    logic [7:0] frame_len;
    logic [7:0] bytes_left;
    logic [7:0] payload_xor;
    logic [7:0] info_bytes [8];
    logic [7:0] payload_mem [PAYLOAD_BYTES];

    rx_item_t   byte_items [$];      // results caused by the byte just deframed
    rx_item_t   pending_items [$];   // results still owed by the block, oldest first
    logic [7:0] frame_bytes [$];     // the frame being sent in the random part

    int          mismatches = 0;
    bit          link_quiet = 1'b0;  // no idling on either side while this is set
    int unsigned item_hold  = 0;     // cycles left in the current output stall
    rx_item_t    want_item;

    function automatic void add_item(logic [1:0] kind, logic [15:0] value, logic [1:0] err);
        rx_item_t it;
        it.kind      = kind;
        it.value     = value;
        it.pos_x     = {info_bytes[0], info_bytes[1]};
        it.pos_y     = {info_bytes[2], info_bytes[3]};
        it.err       = err;
        it.last_item = 1'b0;
        byte_items.push_back(it);
    endfunction

    // Works out the response to a checksum byte and, after an ACK, the replayed payload.
    function automatic void close_frame(logic [7:0] check);
        int i;
        if (frame_len > PAYLOAD_BYTES) begin
            add_item(KIND_NAK, {8'h00, NAK_BYTE}, ERR_OVERFLOW);
        end else if (check != payload_xor) begin
            add_item(KIND_NAK, {8'h00, NAK_BYTE}, ERR_CHECKSUM);
        end else begin
            add_item(KIND_ACK, {8'h00, ACK_BYTE}, ERR_NONE);
            if (frame_kind == TYPE_TEXT) begin
                for (i = 0; i < frame_len; i++)
                    add_item(KIND_TEXT, {8'h00, payload_mem[i]}, ERR_NONE);
            end else if (info_bytes[6] == MODE_RGB888) begin
                // Keep the top 5, 6 and 5 bits of each color byte.
                for (i = 0; i + 3 <= frame_len; i += 3)
                    add_item(KIND_PIXEL, {payload_mem[i][7:3], payload_mem[i + 1][7:2],
                                          payload_mem[i + 2][7:3]}, ERR_NONE);
            end else if (info_bytes[6] == MODE_PAIR) begin
                for (i = 0; i + 2 <= frame_len; i += 2)
                    add_item(KIND_PIXEL, {payload_mem[i], payload_mem[i + 1]}, ERR_NONE);
            end
        end
        byte_items[byte_items.size() - 1].last_item = 1'b1;
        rx_phase    = S_TYPE;
        info_cnt    = 4'd0;
        bytes_left  = 8'd0;
        payload_xor = 8'd0;
    endfunction

    // Advances the mirrored deframer by one received byte and leaves its results in byte_items.
    function automatic void deframe_byte(logic [7:0] b);
        int         idx;
        logic [4:0] info_len;
        byte_items.delete();
        info_len = (frame_kind == TYPE_TEXT) ? INFO_LEN_TEXT : INFO_LEN_IMAGE;
        case (rx_phase)
            S_TYPE: begin
                frame_kind  = b;
                info_cnt    = 4'd0;
                payload_xor = 8'd0;
                rx_phase    = S_SIZE;
            end
            S_SIZE: begin
                frame_len  = b;
                bytes_left = b;
                info_cnt   = 4'd0;
                if (frame_kind == TYPE_TEXT || frame_kind == TYPE_IMAGE)
                    rx_phase = S_INFO;
                else
                    rx_phase = S_HANG;
            end
            S_INFO: begin
                info_bytes[info_cnt[2:0]] = b;
                info_cnt = info_cnt + 4'd1;
                if (info_cnt >= info_len)
                    rx_phase = (bytes_left != 8'd0) ? S_PAYLOAD : S_TERM;
            end
            S_PAYLOAD: begin
                // Bytes past the payload memory still count toward the size and the checksum.
                idx = frame_len - bytes_left;
                if (idx < PAYLOAD_BYTES)
                    payload_mem[idx] = b;
                payload_xor = payload_xor ^ b;
                bytes_left  = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                    rx_phase = S_TERM;
            end
            S_TERM: begin
                if (b == TERM_BYTE)
                    rx_phase = S_CHECK;
            end
            S_CHECK: begin
                close_frame(b);
            end
            default: begin
                rx_phase = S_HANG;
            end
        endcase
    endfunction

    function automatic stim_row_t plain_row(logic [7:0] b);
        stim_row_t row;
        row.rx_byte = b;
        row.known   = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t known_row(logic [7:0] b, logic [1:0] kind, logic [7:0] value,
                                            logic [15:0] x, logic [15:0] y, logic [1:0] err);
        stim_row_t row;
        row.rx_byte        = b;
        row.known          = 1'b1;
        row.item.kind      = kind;
        row.item.value     = {8'h00, value};
        row.item.pos_x     = x;
        row.item.pos_y     = y;
        row.item.err       = err;
        row.item.last_item = 1'b1;
        return row;
    endfunction

    // Builds a whole frame with random info and payload bytes. A few stray bytes may sit
    // between the payload and the terminator, and the checksum can be spoiled on purpose.
    function automatic void build_frame(logic [7:0] ftype, int size, logic [7:0] mode,
                                        bit bad_sum, int junk);
        int         i;
        int         n_info;
        logic [7:0] b;
        logic [7:0] sum;
        frame_bytes.delete();
        sum    = 8'h00;
        n_info = (ftype == TYPE_TEXT) ? 6 : 8;
        frame_bytes.push_back(ftype);
        frame_bytes.push_back(size[7:0]);
        for (i = 0; i < n_info; i++)
            frame_bytes.push_back((ftype == TYPE_IMAGE && i == 6) ? mode : 8'($urandom));
        for (i = 0; i < size; i++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            frame_bytes.push_back(b);
        end
        for (i = 0; i < junk; i++) begin
            b = 8'($urandom);
            if (b == TERM_BYTE)
                b = ~b;
            frame_bytes.push_back(b);
        end
        frame_bytes.push_back(TERM_BYTE);
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
    endfunction

    // Mostly short payloads, now and then a longer one of up to the payload memory size.
    function automatic int draw_size();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(13, PAYLOAD_BYTES);
        return $urandom_range(0, 12);
    endfunction

    // Sends one byte and books the results it causes. The task is entered and left at a
    // rising edge; valid stays high from one byte to the next when there is no gap.
    task automatic send_row(stim_row_t row);
        int gap;
        gap = link_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= row.rx_byte;
        do @(posedge i_clk); while (o_rx_stall);
        deframe_byte(row.rx_byte);
        if (row.known)
            pending_items.push_back(row.item);
        else
            foreach (byte_items[k])
                pending_items.push_back(byte_items[k]);
    endtask

    // Output side: every transfer is checked against the oldest pending result, and then a
    // fresh stall length is drawn, so stalls land on every position within a replay.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_item_valid && !i_item_stall) begin
                if (pending_items.size() == 0) begin
                    $error("unexpected result: kind %0d value 0x%04h", o_item_kind,
                           o_item_value);
                    mismatches++;
                end else begin
                    want_item = pending_items.pop_front();
                    if (o_item_kind !== want_item.kind) begin
                        $error("item_kind: expected %0d, got %0d", want_item.kind,
                               o_item_kind);
                        mismatches++;
                    end
                    if (o_item_value !== want_item.value) begin
                        $error("item_value: expected 0x%04h, got 0x%04h", want_item.value,
                               o_item_value);
                        mismatches++;
                    end
                    if (o_pos_x !== want_item.pos_x) begin
                        $error("pos_x: expected 0x%04h, got 0x%04h", want_item.pos_x,
                               o_pos_x);
                        mismatches++;
                    end
                    if (o_pos_y !== want_item.pos_y) begin
                        $error("pos_y: expected 0x%04h, got 0x%04h", want_item.pos_y,
                               o_pos_y);
                        mismatches++;
                    end
                    if (o_error_code !== want_item.err) begin
                        $error("error_code: expected %0d, got %0d", want_item.err,
                               o_error_code);
                        mismatches++;
                    end
                    if (o_last_item !== want_item.last_item) begin
                        $error("last_item: expected %0d, got %0d", want_item.last_item,
                               o_last_item);
                        mismatches++;
                    end
                end
                item_hold = link_quiet ? 0 : $urandom_range(0, 8);
                if (item_hold != 0)
                    i_item_stall <= 1'b1;
            end else if (item_hold != 0) begin
                item_hold--;
                if (item_hold == 0)
                    i_item_stall <= 1'b0;
            end
        end
    end

    initial begin
        stim_row_t   directed_rows [$];
        int unsigned bytes_sent;
        int          r;
        int          size;
        int          junk;
        bit          bad_sum;
        logic [7:0]  ftype;
        logic [7:0]  mode;

        rx_phase    = S_TYPE;
        info_cnt    = 4'd0;
        frame_kind  = 8'd0;
        frame_len   = 8'd0;
        bytes_left  = 8'd0;
        payload_xor = 8'd0;
        foreach (info_bytes[k])
            info_bytes[k] = 8'd0;
        foreach (payload_mem[k])
            payload_mem[k] = 8'd0;

        directed_rows = {
            // Empty text frame at the largest position, with a stray byte before the
            // terminator. The ACK is the only result.
            plain_row(TYPE_TEXT), plain_row(8'h00),
            plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
            plain_row(8'h00), plain_row(8'h00),
            plain_row(8'h55), plain_row(TERM_BYTE),
            known_row(8'h00, KIND_ACK, ACK_BYTE, 16'hFFFF, 16'hFFFF, ERR_NONE),
            // One-byte text frame where the terminator value shows up as info and payload
            // data, followed by a stray byte and a checksum that does not match.
            plain_row(TYPE_TEXT), plain_row(8'h01),
            plain_row(TERM_BYTE), plain_row(8'h00), plain_row(8'h00), plain_row(TERM_BYTE),
            plain_row(8'hAA), plain_row(8'hBB),
            plain_row(TERM_BYTE), plain_row(8'h80), plain_row(TERM_BYTE),
            known_row(8'h00, KIND_NAK, NAK_BYTE, 16'h1700, 16'h0017, ERR_CHECKSUM),
            // RGB888 image of four bytes: one pixel, and the last byte is dropped.
            plain_row(TYPE_IMAGE), plain_row(8'h04),
            plain_row(8'h12), plain_row(8'h34), plain_row(8'h56), plain_row(8'h78),
            plain_row(8'h00), plain_row(8'h00), plain_row(MODE_RGB888), plain_row(8'h00),
            plain_row(8'hFF), plain_row(8'h80), plain_row(8'h7F), plain_row(8'h01),
            plain_row(TERM_BYTE), plain_row(8'h01)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_row(directed_rows[k]);

        // Random frames. Most are well formed with random content; the rest carry a bad
        // checksum, an unknown image mode, stray bytes or a payload too large to store.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            link_quiet = ($urandom_range(0, 4) == 0);
            r          = $urandom_range(0, 99);
            bad_sum    = ($urandom_range(0, 19) == 0);
            junk       = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            ftype      = TYPE_IMAGE;
            mode       = MODE_RGB888;
            size       = draw_size();
            if (r < 30) begin
                ftype = TYPE_TEXT;
            end else if (r < 55) begin
                mode = MODE_RGB888;
            end else if (r < 75) begin
                mode = MODE_PAIR;
            end else if (r < 80) begin
                mode = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
            end else if (r < 88) begin
                // Oversized payload: the checksum value does not matter here.
                ftype = $urandom_range(0, 1) ? TYPE_TEXT : TYPE_IMAGE;
                size  = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(33, 45);
                mode  = $urandom_range(0, 1) ? MODE_PAIR : MODE_RGB888;
            end else begin
                ftype   = $urandom_range(0, 1) ? TYPE_TEXT : TYPE_IMAGE;
                bad_sum = 1'b1;
            end
            build_frame(ftype, size, mode, bad_sum, junk);
            foreach (frame_bytes[k])
                send_row(plain_row(frame_bytes[k]));
            bytes_sent += frame_bytes.size() - junk;
        end

        // An unknown frame type locks the block up until reset, so this comes last. What
        // follows it, a complete empty text frame included, must cause nothing.
        link_quiet = 1'b0;
        ftype = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
        send_row(plain_row(ftype));
        repeat (10)
            send_row(plain_row(8'($urandom)));
        send_row(plain_row(TYPE_TEXT));
        send_row(plain_row(8'h00));
        repeat (6)
            send_row(plain_row(8'h00));
        send_row(plain_row(TERM_BYTE));
        send_row(plain_row(8'h00));
        i_rx_valid <= 1'b0;

        while (pending_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a run that has not finished by this time is reported as failed.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bfr_pkg.sv
rtl/bfr_ctrl.sv
rtl/bfr_dp.sv
rtl/byte_frame_receiver_rgb565.sv
dv/tb_top.sv
